[rtl/bpmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern match finder package
// Shared sizes, configuration register codes and field widths of the block.
// ----------------------------------------------------------------------------
package bpmf_pkg;

    // Window depth and stream position width
    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;

    // Field widths
    localparam int DATA_W   = 8;
    localparam int OFFSET_W = 32;
    localparam int NUMBER_W = 16;
    localparam int REG_W    = 64;
    localparam int LEN_W    = 5;
    localparam int LIMIT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Pattern bytes held in the two pattern registers
    localparam int REG_PATTERN_BYTES = 2 * REG_W / DATA_W;

    // Derived widths
    localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W     = WIN_IDX_W + LEN_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_MATCH_LIMIT    = 2'd3
    } cfg_reg_t;

    typedef logic [DATA_W-1:0] byte_t;

endpackage

[rtl/bpmf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern match finder channels
// Valid/ready channels for stream bytes, match results and register writes.
// ----------------------------------------------------------------------------

// Stream byte channel
interface bpmf_byte_if;
    logic                          valid;
    logic                          ready;
    logic [bpmf_pkg::DATA_W-1:0]   data_byte;
    logic                          end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// Match result channel
interface bpmf_match_if;
    logic                          valid;
    logic                          ready;
    logic [bpmf_pkg::OFFSET_W-1:0] match_offset;
    logic [bpmf_pkg::NUMBER_W-1:0] match_number;
    logic                          limit_reached;

    modport source (output valid, output match_offset, output match_number,
                    output limit_reached, input ready);
    modport sink   (input valid, input match_offset, input match_number,
                    input limit_reached, output ready);
endinterface

// Register write channel
interface bpmf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bpmf_pkg::CFG_IDX_W-1:0] index;
    logic [bpmf_pkg::REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/byte_pattern_match_finder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern match finder
// Searches a byte stream for a configured pattern of up to 16 bytes and
// reports the start offset and ordinal of matches, overlaps included.
// ----------------------------------------------------------------------------
// Each stream byte taken is held in the input register, and a match word
// is then loaded into the result register. All pattern bytes are compared
// against the byte window in parallel in the cycle that moves a byte from
// the input register into the window, so throughput is one byte per clock
// whenever the result side keeps up; a byte that produces no match never
// waits for the result side. A word with limit_reached set closes reporting
// for the rest of that stream, and a byte marked end_of_stream clears the
// position, the count and the capped state once it has been searched.
// Register writes are taken at any time and must be issued only while no
// byte is in flight.
// ----------------------------------------------------------------------------
module byte_pattern_match_finder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    bpmf_byte_if.sink            byte_in,
    bpmf_match_if.source         match_out,
    bpmf_cfg_if.sink             cfg
);

    // Configuration registers
    logic [bpmf_pkg::REG_W-1:0]   pattern_low_reg;
    logic [bpmf_pkg::REG_W-1:0]   pattern_high_reg;
    logic [bpmf_pkg::LEN_W-1:0]   pattern_length_reg;
    logic [bpmf_pkg::LIMIT_W-1:0] match_limit_reg;

    // Input register
    logic                         s1_valid_reg;
    bpmf_pkg::byte_t              s1_byte_reg;
    logic                         s1_last_reg;

    // Stream state
    bpmf_pkg::byte_t              window_reg [bpmf_pkg::MAX_PATTERN];
    bpmf_pkg::byte_t              window_next [bpmf_pkg::MAX_PATTERN];
    logic [bpmf_pkg::FILL_W-1:0]  fill_reg;
    logic [bpmf_pkg::FILL_W-1:0]  fill_next;
    logic [bpmf_pkg::POSITION_BITS-1:0] position_reg;
    logic [bpmf_pkg::NUMBER_W-1:0] count_reg;
    logic                         capped_reg;

    // Result register
    logic                          out_valid_reg;
    logic [bpmf_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [bpmf_pkg::NUMBER_W-1:0] out_number_reg;
    logic                          out_limit_reg;

    // Match logic
    bpmf_pkg::byte_t               pattern_bytes [bpmf_pkg::MAX_PATTERN];
    logic [2*bpmf_pkg::REG_W-1:0]  pattern_flat;
    logic [bpmf_pkg::CMP_W-1:0]    len_ext;
    logic [bpmf_pkg::CMP_W-1:0]    fill_ext;
    logic                          len_ok;
    logic                          bytes_equal;
    logic                          hit;
    logic [bpmf_pkg::LIMIT_W-1:0]  limit_eff;
    logic [bpmf_pkg::NUMBER_W-1:0] count_inc;
    logic                          cap_now;
    logic [bpmf_pkg::POSITION_BITS-1:0] start_pos;
    logic                          advance;
    logic                          out_load;

    // Accept register writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            match_limit_reg    <= bpmf_pkg::LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (bpmf_pkg::cfg_reg_t'(cfg.index))
                bpmf_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg.data;
                bpmf_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg.data;
                bpmf_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg.data[bpmf_pkg::LEN_W-1:0];
                bpmf_pkg::CFG_MATCH_LIMIT:
                    match_limit_reg <= cfg.data[bpmf_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Shift the new byte into the window, saturate the fill count
    always_comb
    begin
        window_next[0] = s1_byte_reg;
        for (int k = 1; k < bpmf_pkg::MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        if (fill_reg == bpmf_pkg::FILL_W'(bpmf_pkg::MAX_PATTERN))
            fill_next = fill_reg;
        else
            fill_next = fill_reg + bpmf_pkg::FILL_W'(1);
    end

    // Split the pattern registers into bytes; bytes past them read as zero
    assign pattern_flat = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        for (int i = 0; i < bpmf_pkg::MAX_PATTERN; i++)
        begin
            if (i < bpmf_pkg::REG_PATTERN_BYTES)
                pattern_bytes[i] = pattern_flat[bpmf_pkg::DATA_W*i +: bpmf_pkg::DATA_W];
            else
                pattern_bytes[i] = '0;
        end
    end

    // Compare pattern byte i against the window entry len-1-i
    always_comb
    begin
        logic [bpmf_pkg::CMP_W-1:0] diff;
        len_ext     = bpmf_pkg::CMP_W'(pattern_length_reg);
        fill_ext    = bpmf_pkg::CMP_W'(fill_next);
        bytes_equal = 1'b1;
        for (int i = 0; i < bpmf_pkg::MAX_PATTERN; i++)
        begin
            diff = len_ext - bpmf_pkg::CMP_W'(i) - bpmf_pkg::CMP_W'(1);
            if ((bpmf_pkg::CMP_W'(i) < len_ext)
                && (window_next[diff[bpmf_pkg::WIN_IDX_W-1:0]] != pattern_bytes[i]))
                bytes_equal = 1'b0;
        end
    end

    assign len_ok = (pattern_length_reg != '0)
                 && (len_ext <= bpmf_pkg::CMP_W'(bpmf_pkg::MAX_PATTERN));
    assign hit    = len_ok && (fill_ext >= len_ext) && !capped_reg && bytes_equal;

    // Count the match and test it against the limit
    assign limit_eff = (match_limit_reg == '0) ? bpmf_pkg::LIMIT_W'(1) : match_limit_reg;
    assign count_inc = count_reg + bpmf_pkg::NUMBER_W'(1);
    assign cap_now   = bpmf_pkg::LIMIT_W'(count_inc) >= limit_eff;
    assign start_pos = position_reg - bpmf_pkg::POSITION_BITS'(pattern_length_reg)
                     + bpmf_pkg::POSITION_BITS'(1);

    // Advance unless a match word would overwrite one still waiting
    assign advance  = s1_valid_reg && (!hit || !out_valid_reg || match_out.ready);
    assign out_load = advance && hit;
    assign byte_in.ready = !s1_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_in.ready)
            s1_valid_reg <= byte_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.end_of_stream;
        end
    end

    // Window holds payload only; the fill count guards stale entries
    always_ff @(posedge clk)
    begin
        if (advance)
            window_reg <= window_next;
    end

    // Stream counters; clear them after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            position_reg <= '0;
            count_reg    <= '0;
            capped_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                fill_reg     <= '0;
                position_reg <= '0;
                count_reg    <= '0;
                capped_reg   <= 1'b0;
            end
            else
            begin
                fill_reg     <= fill_next;
                position_reg <= position_reg + bpmf_pkg::POSITION_BITS'(1);
                if (hit)
                begin
                    count_reg <= count_inc;
                    if (cap_now)
                        capped_reg <= 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (match_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_offset_reg <= bpmf_pkg::OFFSET_W'(start_pos);
            out_number_reg <= count_inc;
            out_limit_reg  <= cap_now;
        end
    end

    assign match_out.valid         = out_valid_reg;
    assign match_out.match_offset  = out_offset_reg;
    assign match_out.match_number  = out_number_reg;
    assign match_out.limit_reached = out_limit_reg;

    // Never overwrite a match word that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || match_out.ready))
        else $error("match word overwritten while pending");

    // Fill count stays within the window depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bpmf_pkg::FILL_W'(bpmf_pkg::MAX_PATTERN))
        else $error("fill count beyond window depth");

    // Capped state only follows at least one counted match
    a_capped_count: assert property (@(posedge clk) disable iff (!rst_n)
        capped_reg |-> (count_reg != '0))
        else $error("search capped with zero matches");

    // Final byte clears the stream state
    a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (fill_reg == '0 && position_reg == '0
                                      && count_reg == '0 && !capped_reg))
        else $error("stream state not cleared after final byte");

endmodule
